// File: hdl/raster_to_tile_pixel_mapper_defines.svh
// Assertion macros used by the checker of the raster to tile pixel mapper.
`ifndef RASTER_TO_TILE_PIXEL_MAPPER_DEFINES_SVH
`define RASTER_TO_TILE_PIXEL_MAPPER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define RTPM_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define RTPM_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/rtpm_pkg.sv
// Types and constants shared by the raster to tile pixel mapper modules.
`default_nettype none

package rtpm_pkg;

	localparam int BYTE_W      = 8;
	localparam int CHAN_POS_W  = 2;
	localparam int DIM_W       = 13;
	localparam int POS_W       = 12;
	localparam int CH_W        = 3;
	localparam int SBITS_W     = 5;
	localparam int SAMPLE_W    = 16;
	localparam int NUM_W       = 24;
	localparam int OFF_W       = 26;
	localparam int IDX_W       = 3;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [DIM_W-1:0] TILE_DIM_MAX = DIM_W'(4096);

	typedef enum logic [IDX_W-1:0] {
		REG_IMAGE_WIDTH   = 3'd0,
		REG_IMAGE_HEIGHT  = 3'd1,
		REG_CHANNEL_COUNT = 3'd2,
		REG_TILE_WIDTH    = 3'd3,
		REG_TILE_HEIGHT   = 3'd4,
		REG_SAMPLE_BITS   = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                first_of_image;
	} in_beat_t;

	typedef struct packed {
		logic [BYTE_W-1:0] pixel_byte;
		logic              keep;
		logic [NUM_W-1:0]  tile_number;
		logic [OFF_W-1:0]  tile_offset;
		logic              tile_done;
	} out_beat_t;

	// effective (clamped) configuration
	typedef struct packed {
		logic [DIM_W-1:0]   width;
		logic [DIM_W-1:0]   height;
		logic [CH_W-1:0]    channels;
		logic [DIM_W-1:0]   tile_w;
		logic [DIM_W-1:0]   tile_h;
		logic [SBITS_W-1:0] sample_bits;
	} cfg_t;

	// derived limits: width/tile_w, whole-tile extents
	typedef struct packed {
		logic             busy;
		logic [DIM_W-1:0] tiles_across;
		logic [DIM_W-1:0] col_extent;
		logic [DIM_W-1:0] row_extent;
	} lim_t;

	// classified sample waiting for the offset pipeline
	typedef struct packed {
		logic [BYTE_W-1:0]     pixel_byte;
		logic                  keep;
		logic [NUM_W-1:0]      tile_number;
		logic                  tile_done;
		logic [POS_W-1:0]      row_in_tile;
		logic [POS_W-1:0]      column_in_tile;
		logic [CHAN_POS_W-1:0] channel_pos;
	} entry_t;

endpackage

`default_nettype wire

// File: hdl/rtpm_stream_if.sv
// Valid/ready stream interface carrying one payload per beat.
`default_nettype none

interface rtpm_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/rtpm_cfg.sv
// Configuration registers, clamping and iterative derivation of tile limits.
`default_nettype none

module rtpm_cfg #(
	parameter int MAX_WIDTH    = 4096,
	parameter int MAX_HEIGHT   = 4096,
	parameter int MAX_CHANNELS = 4
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         write_enable,
	input  wire logic [rtpm_pkg::IDX_W-1:0]   reg_index,
	input  wire logic [rtpm_pkg::DIM_W-1:0]   write_data,
	output rtpm_pkg::cfg_t                    cfg,
	output rtpm_pkg::lim_t                    lim
);

	localparam int DW = rtpm_pkg::DIM_W;
	localparam int DIM_ALL = (1 << DW) - 1;
	localparam int CH_ALL  = (1 << rtpm_pkg::CH_W) - 1;
	localparam logic [DW-1:0] WIDTH_CAP  =
		(MAX_WIDTH > DIM_ALL) ? DW'(DIM_ALL) : DW'(MAX_WIDTH);
	localparam logic [DW-1:0] HEIGHT_CAP =
		(MAX_HEIGHT > DIM_ALL) ? DW'(DIM_ALL) : DW'(MAX_HEIGHT);
	localparam logic [rtpm_pkg::CH_W-1:0] CH_CAP =
		(MAX_CHANNELS > CH_ALL) ? rtpm_pkg::CH_W'(CH_ALL) : rtpm_pkg::CH_W'(MAX_CHANNELS);
	localparam int STEP_W = $clog2(DW);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DW - 1);

	typedef enum logic [1:0] {ST_LOAD, ST_DIV, ST_MUL, ST_IDLE} state_t;

	logic [DW-1:0]                    image_width_q, image_height_q;
	logic [DW-1:0]                    tile_width_q, tile_height_q;
	logic [rtpm_pkg::CH_W-1:0]        channel_count_q;
	logic [rtpm_pkg::SBITS_W-1:0]     sample_bits_q;

	state_t              state_q;
	logic [STEP_W-1:0]   step_q;
	logic [DW-1:0]       wn_q, hn_q, wr_q, hr_q, wq_q, hq_q;
	logic [DW-1:0]       col_ext_q, row_ext_q;

	logic [DW:0]         w_sh, h_sh, w_diff, h_diff;
	logic                w_ge, h_ge;
	logic [2*DW-1:0]     w_prod, h_prod;

	function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v,
		input logic [DW-1:0] hi);
		logic [DW-1:0] r;
		if (v == '0) r = DW'(1);
		else if (v > hi) r = hi;
		else r = v;
		return r;
	endfunction

	always_comb begin
		cfg.width       = clamp_dim(image_width_q, WIDTH_CAP);
		cfg.height      = clamp_dim(image_height_q, HEIGHT_CAP);
		cfg.tile_w      = clamp_dim(tile_width_q, rtpm_pkg::TILE_DIM_MAX);
		cfg.tile_h      = clamp_dim(tile_height_q, rtpm_pkg::TILE_DIM_MAX);
		cfg.sample_bits = sample_bits_q;
		if (channel_count_q == '0) cfg.channels = rtpm_pkg::CH_W'(1);
		else if (channel_count_q > CH_CAP) cfg.channels = CH_CAP;
		else cfg.channels = channel_count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q   <= DW'(640);
			image_height_q  <= DW'(480);
			channel_count_q <= rtpm_pkg::CH_W'(1);
			tile_width_q    <= DW'(64);
			tile_height_q   <= DW'(64);
			sample_bits_q   <= rtpm_pkg::SBITS_W'(8);
		end else if (write_enable) begin
			case (rtpm_pkg::reg_index_t'(reg_index))
				rtpm_pkg::REG_IMAGE_WIDTH:   image_width_q   <= write_data;
				rtpm_pkg::REG_IMAGE_HEIGHT:  image_height_q  <= write_data;
				rtpm_pkg::REG_CHANNEL_COUNT: channel_count_q <= write_data[rtpm_pkg::CH_W-1:0];
				rtpm_pkg::REG_TILE_WIDTH:    tile_width_q    <= write_data;
				rtpm_pkg::REG_TILE_HEIGHT:   tile_height_q   <= write_data;
				rtpm_pkg::REG_SAMPLE_BITS:   sample_bits_q   <= write_data[rtpm_pkg::SBITS_W-1:0];
				default: ;
			endcase
		end
	end

	// restoring division, one quotient bit per cycle for both dimensions
	assign w_sh   = {wr_q, wn_q[DW-1]};
	assign h_sh   = {hr_q, hn_q[DW-1]};
	assign w_diff = w_sh - {1'b0, cfg.tile_w};
	assign h_diff = h_sh - {1'b0, cfg.tile_h};
	assign w_ge   = w_sh >= {1'b0, cfg.tile_w};
	assign h_ge   = h_sh >= {1'b0, cfg.tile_h};
	assign w_prod = wq_q * cfg.tile_w;
	assign h_prod = hq_q * cfg.tile_h;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			step_q  <= '0;
		end else if (write_enable) begin
			state_q <= ST_LOAD;
		end else begin
			case (state_q)
				ST_LOAD: begin
					wn_q    <= cfg.width;
					hn_q    <= cfg.height;
					wr_q    <= '0;
					hr_q    <= '0;
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					wn_q   <= {wn_q[DW-2:0], 1'b0};
					hn_q   <= {hn_q[DW-2:0], 1'b0};
					wr_q   <= w_ge ? w_diff[DW-1:0] : w_sh[DW-1:0];
					hr_q   <= h_ge ? h_diff[DW-1:0] : h_sh[DW-1:0];
					wq_q   <= {wq_q[DW-2:0], w_ge};
					hq_q   <= {hq_q[DW-2:0], h_ge};
					step_q <= step_q + STEP_W'(1);
					if (step_q == LAST_STEP) state_q <= ST_MUL;
				end
				ST_MUL: begin
					col_ext_q <= w_prod[DW-1:0];
					row_ext_q <= h_prod[DW-1:0];
					state_q   <= ST_IDLE;
				end
				ST_IDLE: ;
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign lim.busy         = (state_q != ST_IDLE);
	assign lim.tiles_across = wq_q;
	assign lim.col_extent   = col_ext_q;
	assign lim.row_extent   = row_ext_q;

endmodule

`default_nettype wire

// File: hdl/rtpm_front.sv
// Front end: accepts samples, tracks raster and tile position, classifies each beat.
`default_nettype none

module rtpm_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  rtpm_pkg::in_beat_t      in_data,
	output logic                    in_ready,
	input  rtpm_pkg::cfg_t          cfg,
	input  rtpm_pkg::lim_t          lim,
	input  wire logic               q_full,
	output logic                    push,
	output rtpm_pkg::entry_t        entry
);

	localparam int PW = rtpm_pkg::POS_W;
	localparam int DW = rtpm_pkg::DIM_W;
	localparam int CW = rtpm_pkg::CH_W;
	localparam int NW = rtpm_pkg::NUM_W;
	localparam int XW = 2 * DW;

	logic [rtpm_pkg::CHAN_POS_W-1:0] cp_q, cp, cp_nx;
	logic [PW-1:0] colp_q, rowp_q, cit_q, rit_q, tcol_q;
	logic [PW-1:0] colp, rowp, cit, rit, tcol;
	logic [PW-1:0] colp_nx, rowp_nx, cit_nx, rit_nx, tcol_nx;
	logic [NW-1:0] trb_q, trb, trb_nx;
	logic [DW-1:0] ta_q, ta;
	logic [XW-1:0] tap_q, tap, ta_prod;

	logic          first, keep, done;
	logic [CW-1:0] cp_inc;
	logic [DW-1:0] col_inc, cit_inc, row_inc, rit_inc;
	logic [rtpm_pkg::SBITS_W-1:0] shamt;
	logic [rtpm_pkg::SAMPLE_W-1:0] shifted;
	logic [rtpm_pkg::BYTE_W-1:0] pix;

	assign in_ready = !lim.busy && !q_full;
	assign push     = in_valid && in_ready;
	assign first    = in_data.first_of_image;
	assign ta_prod  = ta_q * cfg.tile_w;

	// image start: counters read as cleared, tile count taken from the limit unit
	always_comb begin
		cp   = first ? '0 : cp_q;
		colp = first ? '0 : colp_q;
		rowp = first ? '0 : rowp_q;
		cit  = first ? '0 : cit_q;
		rit  = first ? '0 : rit_q;
		tcol = first ? '0 : tcol_q;
		trb  = first ? '0 : trb_q;
		ta   = first ? lim.tiles_across : ta_q;
		tap  = first ? XW'(lim.col_extent) : tap_q;
	end

	assign shamt   = cfg.sample_bits - rtpm_pkg::SBITS_W'(rtpm_pkg::BYTE_W);
	assign shifted = in_data.sample >> shamt;
	assign pix     = (cfg.sample_bits <= rtpm_pkg::SBITS_W'(rtpm_pkg::BYTE_W)) ?
		in_data.sample[rtpm_pkg::BYTE_W-1:0] : shifted[rtpm_pkg::BYTE_W-1:0];

	assign cp_inc  = CW'(cp) + CW'(1);
	assign col_inc = DW'(colp) + DW'(1);
	assign cit_inc = DW'(cit) + DW'(1);
	assign row_inc = DW'(rowp) + DW'(1);
	assign rit_inc = DW'(rit) + DW'(1);

	assign keep = (XW'(colp) < tap) && (DW'(rowp) < lim.row_extent);
	assign done = keep && (cp_inc == cfg.channels) && (cit_inc == cfg.tile_w)
		&& (rit_inc == cfg.tile_h);

	always_comb begin
		entry.pixel_byte     = pix;
		entry.keep           = keep;
		entry.tile_number    = keep ? NW'(trb + NW'(tcol)) : '0;
		entry.tile_done      = done;
		entry.row_in_tile    = keep ? rit : '0;
		entry.column_in_tile = keep ? cit : '0;
		entry.channel_pos    = keep ? cp : '0;
	end

	// position advance: channel, then column, then row
	always_comb begin
		cp_nx   = cp_inc[rtpm_pkg::CHAN_POS_W-1:0];
		colp_nx = colp;
		rowp_nx = rowp;
		cit_nx  = cit;
		rit_nx  = rit;
		tcol_nx = tcol;
		trb_nx  = trb;
		if (cp_inc >= cfg.channels) begin
			cp_nx   = '0;
			colp_nx = col_inc[PW-1:0];
			cit_nx  = cit_inc[PW-1:0];
			if (cit_inc >= cfg.tile_w) begin
				cit_nx  = '0;
				tcol_nx = tcol + PW'(1);
			end
			if (col_inc >= cfg.width) begin
				colp_nx = '0;
				cit_nx  = '0;
				tcol_nx = '0;
				rowp_nx = row_inc[PW-1:0];
				rit_nx  = rit_inc[PW-1:0];
				if (rit_inc >= cfg.tile_h) begin
					rit_nx = '0;
					trb_nx = trb + NW'(ta);
				end
				if (row_inc >= cfg.height) begin
					rowp_nx = '0;
					rit_nx  = '0;
					trb_nx  = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_q   <= '0;
			colp_q <= '0;
			rowp_q <= '0;
			cit_q  <= '0;
			rit_q  <= '0;
			tcol_q <= '0;
			trb_q  <= '0;
			ta_q   <= '0;
			tap_q  <= '0;
		end else begin
			tap_q <= (push && first) ? XW'(lim.col_extent) : ta_prod;
			if (push) begin
				cp_q   <= cp_nx;
				colp_q <= colp_nx;
				rowp_q <= rowp_nx;
				cit_q  <= cit_nx;
				rit_q  <= rit_nx;
				tcol_q <= tcol_nx;
				trb_q  <= trb_nx;
				ta_q   <= ta;
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/rtpm_queue.sv
// Short register queue between the front end and the offset pipeline.
`default_nettype none

module rtpm_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  rtpm_pkg::entry_t   din,
	output logic               full,
	input  wire logic          pop,
	output rtpm_pkg::entry_t   dout,
	output logic               not_empty
);

	localparam int DEPTH = rtpm_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	rtpm_pkg::entry_t  slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign dout      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop) rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !pop) count_q <= count_q + CNT_W'(1);
			else if (pop && !push) count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

`default_nettype wire

// File: hdl/rtpm_back.sv
// Back end: two-stage tile offset pipeline whose second stage is the output register.
`default_nettype none

module rtpm_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  rtpm_pkg::cfg_t        cfg,
	input  wire logic             q_valid,
	input  rtpm_pkg::entry_t      q_entry,
	output logic                  pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output rtpm_pkg::out_beat_t   out_data
);

	localparam int OW = rtpm_pkg::OFF_W;
	localparam int PW = rtpm_pkg::POS_W;
	localparam int DW = rtpm_pkg::DIM_W;

	logic                   v_s1, v_s2;
	rtpm_pkg::entry_t       e_s1;
	logic [OW-1:0]          lin_s1;
	rtpm_pkg::out_beat_t    beat_s2;

	logic                   adv1, adv2;
	logic [PW+DW-1:0]       row_scaled;
	logic [OW-1:0]          lin_d;
	logic [OW+rtpm_pkg::CH_W-1:0] chan_scaled;

	assign adv2 = !v_s2 || out_ready;
	assign adv1 = !v_s1 || adv2;
	assign pop  = q_valid && adv1;

	// stage 1: row_in_tile * tile_w + column_in_tile
	assign row_scaled = q_entry.row_in_tile * cfg.tile_w;
	assign lin_d      = OW'(row_scaled) + OW'(q_entry.column_in_tile);
	// stage 2: scale by channels, add channel position
	assign chan_scaled = lin_s1 * cfg.channels;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= q_valid;
			if (adv2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			e_s1   <= q_entry;
			lin_s1 <= lin_d;
		end
		if (adv2 && v_s1) begin
			beat_s2.pixel_byte  <= e_s1.pixel_byte;
			beat_s2.keep        <= e_s1.keep;
			beat_s2.tile_number <= e_s1.tile_number;
			beat_s2.tile_offset <= chan_scaled[OW-1:0] + OW'(e_s1.channel_pos);
			beat_s2.tile_done   <= e_s1.tile_done;
		end
	end

	assign out_valid = v_s2;
	assign out_data  = beat_s2;

endmodule

`default_nettype wire

// File: hdl/raster_to_tile_pixel_mapper.sv
// Raster to tile pixel mapper top level: config unit, front end, queue, offset pipeline.
// An accepted input beat passes the queue, stage 1 and the stage 2 output register in turn.
// Throughput: one beat per cycle when ready, set by the front end position counters.
// Reset clears all position counters and queue/pipeline state; config returns to defaults.
// After reset and after every config write, samples.ready stays low
// while the limit unit divides width/height by the tile size, one bit per cycle.
`default_nettype none

module raster_to_tile_pixel_mapper #(
	parameter int MAX_WIDTH    = 4096,
	parameter int MAX_HEIGHT   = 4096,
	parameter int MAX_CHANNELS = 4
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	rtpm_stream_if.sink                      samples,
	rtpm_stream_if.source                    mapped,
	input  wire logic                        write_enable,
	input  wire logic [rtpm_pkg::IDX_W-1:0]  reg_index,
	input  wire logic [rtpm_pkg::DIM_W-1:0]  write_data
);

	// effective config and derived tile limits
	rtpm_pkg::cfg_t   cfg;
	rtpm_pkg::lim_t   lim;

	// front end to queue
	logic             q_push, q_full;
	rtpm_pkg::entry_t q_din;

	// queue to offset pipeline
	logic             q_pop, q_not_empty;
	rtpm_pkg::entry_t q_dout;

	logic             front_ready;
	logic             out_valid;
	rtpm_pkg::out_beat_t out_data;

	// Config registers plus the limit unit: tiles_across = width / tile_w and
	// the whole-tile extents, recomputed after each write. Busy blocks input.
	rtpm_cfg #(
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_HEIGHT   (MAX_HEIGHT),
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.write_enable (write_enable),
		.reg_index    (reg_index),
		.write_data   (write_data),
		.cfg          (cfg),
		.lim          (lim)
	);

	// Front end: reduces the sample to a byte, decides keep/done/tile number
	// and advances the raster and tile counters on every accepted beat.
	rtpm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_data  (samples.data),
		.in_ready (front_ready),
		.cfg      (cfg),
		.lim      (lim),
		.q_full   (q_full),
		.push     (q_push),
		.entry    (q_din)
	);

	assign samples.ready = front_ready;

	// Queue decouples the front end from output backpressure.
	rtpm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.din       (q_din),
		.full      (q_full),
		.pop       (q_pop),
		.dout      (q_dout),
		.not_empty (q_not_empty)
	);

	// Back end: offset = (row_in_tile * tile_w + column_in_tile) * channels
	// + channel_pos over two registered multiply stages; stage 2 is the
	// output register.
	rtpm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_valid   (q_not_empty),
		.q_entry   (q_dout),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_ready (mapped.ready),
		.out_data  (out_data)
	);

	assign mapped.valid = out_valid;
	assign mapped.data  = out_data;

endmodule

`default_nettype wire

// File: hdl/rtpm_checker.sv
// Port-level checker for the raster to tile pixel mapper and its bind.
`default_nettype none

`include "raster_to_tile_pixel_mapper_defines.svh"

module rtpm_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_ready,
	input wire logic                          write_enable,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic                          out_keep,
	input wire logic                          out_done,
	input wire logic [rtpm_pkg::NUM_W-1:0]    out_number,
	input wire logic [rtpm_pkg::OFF_W-1:0]    out_offset,
	input wire logic [rtpm_pkg::BYTE_W-1:0]   out_pixel
);

	`RTPM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_pixel) && $stable(out_keep) && $stable(out_number) && $stable(out_offset) && $stable(out_done), "stalled output beat changed")
	`RTPM_ASSERT_NOW(a_drop_zero, clk, arst_n, out_valid && !out_keep, out_number == '0 && out_offset == '0 && !out_done, "dropped beat carries tile fields")
	`RTPM_ASSERT_NEXT(a_cfg_blocks, clk, arst_n, write_enable, !in_ready, "input taken while limits recompute")

endmodule

bind raster_to_tile_pixel_mapper rtpm_checker u_rtpm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (samples.ready),
	.write_enable (write_enable),
	.out_valid    (mapped.valid),
	.out_ready    (mapped.ready),
	.out_keep     (mapped.data.keep),
	.out_done     (mapped.data.tile_done),
	.out_number   (mapped.data.tile_number),
	.out_offset   (mapped.data.tile_offset),
	.out_pixel    (mapped.data.pixel_byte)
);

`default_nettype wire
